FILE: sv/bavg_pkg.sv
// ----------------------------------------------------------------------------
// bavg_pkg
// Shared constants and types for the box average downsampler.
// ----------------------------------------------------------------------------
package bavg_pkg;

    localparam int PIX_W            = 8;
    localparam int SUM_W            = 14;
    localparam int CFG_W            = 13;
    localparam int CFG_IDX_W        = 2;
    localparam int FACTOR_W         = 2;
    localparam int BAND_W           = 3;
    localparam int ROW_W            = 12;
    localparam int DEFAULT_MAX_WIDTH = 4096;
    localparam int MAX_HEIGHT       = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [FACTOR_W-1:0] RST_FACTOR_LOG2  = 2'd1;
    localparam logic [CFG_W-1:0]    RST_LINE_WIDTH   = 13'd640;
    localparam logic [CFG_W-1:0]    RST_FRAME_HEIGHT = 13'd480;

    // control that travels with a pixel from the read stage to the update stage
    typedef struct packed {
        logic wr;
        logic first_row;
        logic last_row;
        logic pos_first;
        logic pos_last;
        logic row_last;
        logic frame_last;
    } bavg_ctl_t;

endpackage

FILE: sv/box_average_downsampler.sv
// ----------------------------------------------------------------------------
// box_average_downsampler
// Averages each F by F block of an 8-bit grey raster stream (F = 2, 4, 8)
// into one output pixel; partial blocks at the right and bottom are dropped.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless s_ready drops (skid stage full, or a
// result meeting a stalled output). A pixel's result, if any, goes from the
// read stage to the output register, or to the skid stage while that is held.
// The rate is set by the column-sum line store: one read per pixel at
// acceptance and the write-back in the following cycle, on separate ports.
// An output register plus a one-entry skid stage keep the input flowing
// while a result waits. The line store needs no clearing pass after reset.
// Configuration must be written only while idle, which is not enforced.
module box_average_downsampler
    import bavg_pkg::*;
#(
    parameter int MAX_WIDTH = bavg_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bavg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bavg_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bavg_pkg::PIX_W-1:0]     s_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bavg_pkg::PIX_W-1:0]     m_out_pixel,
    output logic                           m_row_last,
    output logic                           m_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int HW = CFG_W;

    // configuration
    logic [FACTOR_W-1:0] factor_log2_reg;
    logic [CFG_W-1:0]    line_width_reg;
    logic [CFG_W-1:0]    frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_log2_reg  <= RST_FACTOR_LOG2;
            line_width_reg   <= RST_LINE_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FACTOR_LOG2:  factor_log2_reg  <= cfg_wdata[FACTOR_W-1:0];
                CFG_LINE_WIDTH:   line_width_reg   <= cfg_wdata;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // derived geometry
    logic [FACTOR_W-1:0] k;
    logic [BAND_W-1:0]   fmask;
    logic [LW-1:0]       lw_ext;
    logic [LW-1:0]       w_eff;
    logic [LW-1:0]       used_w;
    logic [HW-1:0]       h_eff;
    logic [HW-1:0]       used_h;

    always_comb begin
        k      = (factor_log2_reg == '0) ? FACTOR_W'(1) : factor_log2_reg;
        fmask  = BAND_W'((4'd1 << k) - 4'd1);
        lw_ext = LW'(line_width_reg);
        if (lw_ext == '0) begin
            w_eff = LW'(1);
        end else if (lw_ext > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end else begin
            w_eff = lw_ext;
        end
        if (frame_height_reg == '0) begin
            h_eff = HW'(1);
        end else if (frame_height_reg > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = frame_height_reg;
        end
        used_w = w_eff & ~LW'(fmask);
        used_h = h_eff & ~HW'(fmask);
    end

    // position counters and read stage
    logic [CW-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic [BAND_W-1:0] band_row;
    logic [LW-1:0]     col_inc;
    logic [HW-1:0]     row_inc;
    bavg_ctl_t         ctl_next;
    logic              accept;

    logic              s1_valid_reg;
    bavg_ctl_t         s1_ctl_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    logic [CW-1:0]     s1_addr_reg;
    logic [SUM_W-1:0]  rd_data_reg;

    logic              skid_valid_reg;
    logic              out_valid_reg;

    assign accept = s_valid && s_ready;

    always_comb begin
        band_row = band_reg & fmask;
        col_inc  = LW'(col_reg) + LW'(1);
        row_inc  = HW'(row_reg) + HW'(1);

        ctl_next.wr         = (LW'(col_reg) < used_w) && (HW'(row_reg) < used_h);
        ctl_next.first_row  = (band_row == '0);
        ctl_next.last_row   = (band_row == fmask);
        ctl_next.pos_first  = ((BAND_W'(col_reg) & fmask) == '0);
        ctl_next.pos_last   = ((BAND_W'(col_reg) & fmask) == fmask);
        ctl_next.row_last   = (col_inc == used_w);
        ctl_next.frame_last = ctl_next.row_last && (row_inc == used_h);

        col_next  = col_reg;
        row_next  = row_reg;
        band_next = band_reg;
        if (col_inc >= w_eff) begin
            col_next = '0;
            if (row_inc >= h_eff) begin
                row_next  = '0;
                band_next = '0;
            end else begin
                row_next  = row_inc[ROW_W-1:0];
                band_next = (band_row + BAND_W'(1)) & fmask;
            end
        end else begin
            col_next = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            band_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                band_reg <= band_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg  <= ctl_next;
            s1_px_reg   <= s_pixel;
            s1_addr_reg <= col_reg;
        end
    end

    // line store of column sums
    logic [SUM_W-1:0] col_mem [MAX_WIDTH];
    logic [SUM_W-1:0] csum;
    logic             mem_wr;

    assign mem_wr = s1_valid_reg && s1_ctl_reg.wr;
    assign csum   = s1_ctl_reg.first_row ? SUM_W'(s1_px_reg)
                                         : rd_data_reg + SUM_W'(s1_px_reg);

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            col_mem[s1_addr_reg] <= csum;
        end
        if (accept) begin
            rd_data_reg <= col_mem[col_reg];
        end
    end

    // horizontal accumulator
    logic [SUM_W-1:0] block_sum_reg, block_sum_next;
    logic [SUM_W-1:0] avg_full;
    logic             s1_res;

    always_comb begin
        block_sum_next = s1_ctl_reg.pos_first ? csum : block_sum_reg + csum;
        avg_full       = block_sum_next >> {k, 1'b0};
        s1_res         = mem_wr && s1_ctl_reg.last_row && s1_ctl_reg.pos_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_sum_reg <= '0;
        end else if (mem_wr && s1_ctl_reg.last_row) begin
            block_sum_reg <= block_sum_next;
        end
    end

    // output register and skid stage
    logic [PIX_W-1:0] out_pixel_reg, skid_pixel_reg;
    logic             out_rlast_reg, skid_rlast_reg;
    logic             out_flast_reg, skid_flast_reg;
    logic             out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !skid_valid_reg && !(s1_res && out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= s1_res;
            end else begin
                out_valid_reg <= s1_res;
            end
        end else if (s1_res) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_pixel_reg <= skid_pixel_reg;
                out_rlast_reg <= skid_rlast_reg;
                out_flast_reg <= skid_flast_reg;
            end else if (s1_res) begin
                out_pixel_reg <= avg_full[PIX_W-1:0];
                out_rlast_reg <= s1_ctl_reg.row_last;
                out_flast_reg <= s1_ctl_reg.frame_last;
            end
        end
        if (s1_res && (skid_valid_reg || !out_free)) begin
            skid_pixel_reg <= avg_full[PIX_W-1:0];
            skid_rlast_reg <= s1_ctl_reg.row_last;
            skid_flast_reg <= s1_ctl_reg.frame_last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_pixel  = out_pixel_reg;
    assign m_row_last   = out_rlast_reg;
    assign m_frame_last = out_flast_reg;

endmodule

FILE: sv/bavg_checker.sv
// ----------------------------------------------------------------------------
// bavg_checker
// Port-level checks for the box average downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module bavg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [bavg_pkg::PIX_W-1:0]     m_out_pixel,
    input logic                           m_row_last,
    input logic                           m_frame_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_pixel)
            && $stable(m_row_last) && $stable(m_frame_last))
        else $error("result beat changed while stalled");

    // end of frame is also end of an output row
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> m_row_last)
        else $error("frame_last without row_last");

    // a rising result beat traces back to an accepted input beat via the read stage
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result beat without a matching input beat");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

endmodule

bind box_average_downsampler bavg_checker u_bavg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_pixel  (m_out_pixel),
    .m_row_last   (m_row_last),
    .m_frame_last (m_frame_last)
);

FILE: bench/box_average_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_average_checker
// Watches the configuration port and both streams of the box average
// downsampler. Every accepted pixel runs through a bit-accurate model of the
// column-sum store and block accumulator. The averages it predicts are queued
// in order and compared field by field with each result beat.
// ----------------------------------------------------------------------------
module box_average_checker
    import bavg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [PIX_W-1:0]     s_pixel,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [PIX_W-1:0]     m_out_pixel,
    input  logic                 m_row_last,
    input  logic                 m_frame_last,
    output int                   mismatches,
    output int                   outstanding
);

    localparam int unsigned MAX_W = DEFAULT_MAX_WIDTH;
    localparam int unsigned MAX_H = MAX_HEIGHT;
    localparam int unsigned SUM_MASK = (1 << SUM_W) - 1;

    typedef struct packed {
        logic [PIX_W-1:0] avg;
        logic             row_last;
        logic             frame_last;
    } avg_beat_t;

    avg_beat_t            expected_avgs[$];

    logic [FACTOR_W-1:0]  factor_q;
    logic [CFG_W-1:0]     width_q;
    logic [CFG_W-1:0]     height_q;
    logic [SUM_W-1:0]     col_sums [MAX_W];
    int unsigned          blk_sum;
    int unsigned          col_idx;
    int unsigned          row_idx;
    int unsigned          band_idx;

    task automatic accumulate_pixel(input logic [PIX_W-1:0] px);
        int unsigned k;
        int unsigned f;
        int unsigned w;
        int unsigned h;
        int unsigned used_w;
        int unsigned used_h;
        int unsigned col;
        int unsigned band_row;
        int unsigned pos;
        int unsigned csum;
        avg_beat_t   beat;
        k = (factor_q == 0) ? 1 : factor_q;
        f = 1 << k;
        w = (width_q == 0) ? 1 : ((width_q > MAX_W) ? MAX_W : width_q);
        h = (height_q == 0) ? 1 : ((height_q > MAX_H) ? MAX_H : height_q);
        used_w = (w >> k) << k;
        used_h = (h >> k) << k;
        col = col_idx;
        band_row = band_idx & (f - 1);
        if (col < used_w && row_idx < used_h && col < MAX_W) begin
            if (band_row == 0)
                csum = px;
            else
                csum = (col_sums[col] + px) & SUM_MASK;
            col_sums[col] = csum[SUM_W-1:0];
            if (band_row == f - 1) begin
                pos = col & (f - 1);
                if (pos == 0)
                    blk_sum = csum;
                else
                    blk_sum = (blk_sum + csum) & SUM_MASK;
                if (pos == f - 1) begin
                    beat.avg        = PIX_W'(blk_sum >> (2 * k));
                    beat.row_last   = (col + 1 == used_w);
                    beat.frame_last = beat.row_last && (row_idx + 1 == used_h);
                    expected_avgs.push_back(beat);
                end
            end
        end
        if (col + 1 >= w) begin
            col_idx = 0;
            if (row_idx + 1 >= h) begin
                row_idx  = 0;
                band_idx = 0;
            end else begin
                row_idx  = row_idx + 1;
                band_idx = (band_row + 1) & (f - 1);
            end
        end else begin
            col_idx = col + 1;
        end
    endtask

    always @(posedge aclk) begin
        avg_beat_t want;
        if (!aresetn) begin
            factor_q   = RST_FACTOR_LOG2;
            width_q    = RST_LINE_WIDTH;
            height_q   = RST_FRAME_HEIGHT;
            blk_sum    = 0;
            col_idx    = 0;
            row_idx    = 0;
            band_idx   = 0;
            mismatches = 0;
            expected_avgs.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FACTOR_LOG2:  factor_q = cfg_wdata[FACTOR_W-1:0];
                    CFG_LINE_WIDTH:   width_q  = cfg_wdata;
                    CFG_FRAME_HEIGHT: height_q = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                accumulate_pixel(s_pixel);
            if (m_valid && m_ready) begin
                if (expected_avgs.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result beat avg=%0d row_last=%0b frame_last=%0b",
                                 $time, m_out_pixel, m_row_last, m_frame_last);
                    mismatches++;
                end else begin
                    want = expected_avgs.pop_front();
                    if (m_out_pixel !== want.avg || m_row_last !== want.row_last ||
                        m_frame_last !== want.frame_last) begin
                        if (mismatches < 10)
                            $display({"%0t: result mismatch: avg exp %0d got %0d, ",
                                      "row_last exp %0b got %0b, frame_last exp %0b got %0b"},
                                     $time, want.avg, m_out_pixel, want.row_last, m_row_last,
                                     want.frame_last, m_frame_last);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = expected_avgs.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the box average downsampler: a directed set of frames covering
// the extreme pixel values, every factor, clamped sizes, frames too small for
// a block and configuration changes in mid-frame, then random whole frames
// under four idling regimes, with one long output hold-off to back up the
// input. Prediction and comparison are done by box_average_checker.
// ----------------------------------------------------------------------------
module testbench;
    import bavg_pkg::*;

    localparam int CLK_HALF         = 2;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS     = 500;
    localparam int TIMEOUT_NS       = 6_000_000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FACTOR_LOG2;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PIX_W-1:0]     m_out_pixel;
    logic                 m_row_last;
    logic                 m_frame_last;

    int                   mismatches;
    int                   outstanding;
    int                   idle_pct = 0;
    int                   stall_pct = 0;
    logic                 long_hold = 1'b0;

    box_average_downsampler dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_pixel  (m_out_pixel),
        .m_row_last   (m_row_last),
        .m_frame_last (m_frame_last)
    );

    box_average_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_pixel  (m_out_pixel),
        .m_row_last   (m_row_last),
        .m_frame_last (m_frame_last),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** box_average_downsampler: FAILED **");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    task automatic send_frame(input int n, input int lo, input int hi);
        int i;
        for (i = 0; i < n; i++) begin
            while ($urandom_range(99, 0) < idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_pixel <= PIX_W'($urandom_range(hi, lo));
            do @(posedge aclk); while (!s_ready);
        end
    endtask

    // wait until every predicted beat is out and the pipeline has settled
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input int factor, input int width, input int height);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FACTOR_LOG2;
        cfg_wdata <= CFG_W'(factor);
        @(posedge aclk);
        cfg_index <= CFG_LINE_WIDTH;
        cfg_wdata <= CFG_W'(width);
        @(posedge aclk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_wdata <= CFG_W'(height);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int phase;
        int sent;
        int factor;
        int width;
        int height;
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames
        set_config(1, 2, 2);
        send_frame(4, 255, 255);
        drain();
        set_config(1, 4, 2);
        send_frame(8, 0, 0);
        drain();
        set_config(0, 3, 3);
        send_frame(9, 0, 255);
        drain();
        set_config(3, 8, 8);
        send_frame(64, 255, 255);
        send_frame(64, 0, 255);
        drain();
        set_config(2, 8, 4);
        send_frame(32, 0, 255);
        drain();
        set_config(2, 3, 5);
        send_frame(15, 0, 255);
        drain();
        set_config(1, 0, 2);
        send_frame(2, 0, 255);
        drain();
        set_config(1, 4, 0);
        send_frame(4, 0, 255);
        drain();
        // factor drops from 4x to 2x after the first row of a band
        set_config(2, 4, 4);
        send_frame(4, 0, 255);
        drain();
        set_config(1, 4, 4);
        send_frame(12, 0, 255);
        drain();
        // width shrinks below the current column in mid-row
        set_config(1, 16, 4);
        send_frame(26, 0, 255);
        drain();
        set_config(1, 6, 4);
        send_frame(13, 0, 255);
        drain();

        // random whole frames under each idling regime
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            if (phase == 0) begin
                set_config(1, 16, 16);
                long_hold = 1'b1;
                send_frame(256, 0, 255);
                drain();
            end
            sent = 0;
            while (sent < RANDOM_ITEMS / 4) begin
                factor = $urandom_range(3, 0);
                if ($urandom_range(9, 0) == 0) begin
                    width  = $urandom_range(64, 33);
                    height = $urandom_range(10, 1);
                end else begin
                    width  = $urandom_range(20, 0);
                    height = $urandom_range(20, 0);
                end
                n = ((width == 0) ? 1 : width) * ((height == 0) ? 1 : height);
                set_config(factor, width, height);
                repeat ($urandom_range(3, 1)) begin
                    if (sent < RANDOM_ITEMS / 4) begin
                        if ($urandom_range(7, 0) == 0)
                            send_frame(n, 255, 255);
                        else if ($urandom_range(7, 0) == 0)
                            send_frame(n, 0, 0);
                        else
                            send_frame(n, 0, 255);
                        sent += n;
                    end
                end
                drain();
            end
        end

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("** box_average_downsampler: PASSED **");
        else
            $display("** box_average_downsampler: FAILED **");
        $finish;
    end

endmodule
